>>> sv/pwlr_pkg.sv
// shared types, register codes and constants of the pulse-width link responder
package pwlr_pkg;

  // default sizes handed to the top level parameters
  localparam int RX_FRAME_BYTES_DEF   = 13;
  localparam int REPLY_DATA_BYTES_DEF = 6;

  // configuration register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_SYNC_MIN      = 3'd0;
  localparam logic [2:0] REG_SYNC_MAX      = 3'd1;
  localparam logic [2:0] REG_BIT_SPLIT     = 3'd2;
  localparam logic [2:0] REG_IDLE_END      = 3'd3;
  localparam logic [2:0] REG_TX_SYNC_TICKS = 3'd4;
  localparam logic [2:0] REG_TX_ZERO_LOW   = 3'd5;

  localparam int PADDR_W = 5;

  // reset values of the registers
  localparam logic [7:0] SYNC_MIN_RST      = 8'd35;
  localparam logic [7:0] SYNC_MAX_RST      = 8'd45;
  localparam logic [7:0] BIT_SPLIT_RST     = 8'd3;
  localparam logic [7:0] IDLE_END_RST      = 8'd40;
  localparam logic [7:0] TX_SYNC_TICKS_RST = 8'd20;
  localparam logic [4:0] TX_ZERO_LOW_RST   = 5'd3;

  // request headers and reply headers
  localparam logic [7:0] REQ_HDR_MERGE = 8'hA0;
  localparam logic [7:0] REQ_HDR_MASK  = 8'hA1;
  localparam logic [7:0] RPL_HDR_MERGE = 8'hA0;
  localparam logic [7:0] RPL_HDR_MASK  = 8'hA3;
  localparam logic [7:0] KEEP_HI_MASK  = 8'hC0;
  localparam logic [7:0] TAKE_LO_MASK  = 8'h3F;
  localparam logic [7:0] CLR_FLAG_MASK = 8'hF7;
  localparam logic [7:0] COUNT_MAX     = 8'hFF;

  typedef struct packed {
    logic rx_tick;
    logic tx_tick;
    logic line_in;
  } sample_t;

  typedef struct packed {
    logic       line_out;
    logic       frame_done;
    logic [3:0] bytes_received;
    logic       tx_busy;
  } result_t;

  typedef struct packed {
    logic [7:0] sync_min;
    logic [7:0] sync_max;
    logic [7:0] bit_split;
    logic [7:0] idle_end;
    logic [7:0] tx_sync_ticks;
    logic [4:0] tx_zero_low;
  } cfg_t;

endpackage

>>> sv/pwlr_cfg.sv
// apb configuration registers
module pwlr_cfg import pwlr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [2:0] index;
  logic       wr;

  assign index  = paddr[PADDR_W-1:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_min      <= SYNC_MIN_RST;
      cfg.sync_max      <= SYNC_MAX_RST;
      cfg.bit_split     <= BIT_SPLIT_RST;
      cfg.idle_end      <= IDLE_END_RST;
      cfg.tx_sync_ticks <= TX_SYNC_TICKS_RST;
      cfg.tx_zero_low   <= TX_ZERO_LOW_RST;
    end else if (wr) begin
      case (index)
        REG_SYNC_MIN:      cfg.sync_min      <= pwdata[7:0];
        REG_SYNC_MAX:      cfg.sync_max      <= pwdata[7:0];
        REG_BIT_SPLIT:     cfg.bit_split     <= pwdata[7:0];
        REG_IDLE_END:      cfg.idle_end      <= pwdata[7:0];
        REG_TX_SYNC_TICKS: cfg.tx_sync_ticks <= pwdata[7:0];
        REG_TX_ZERO_LOW:   cfg.tx_zero_low   <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_SYNC_MIN:      prdata = 32'(cfg.sync_min);
      REG_SYNC_MAX:      prdata = 32'(cfg.sync_max);
      REG_BIT_SPLIT:     prdata = 32'(cfg.bit_split);
      REG_IDLE_END:      prdata = 32'(cfg.idle_end);
      REG_TX_SYNC_TICKS: prdata = 32'(cfg.tx_sync_ticks);
      REG_TX_ZERO_LOW:   prdata = 32'(cfg.tx_zero_low);
      default:           prdata = 32'd0;
    endcase
  end

endmodule

>>> sv/pwlr_rx.sv
// receiver: run-length counting, sync detection, bit capture and frame end
module pwlr_rx import pwlr_pkg::*; #(
  parameter int RX_FRAME_BYTES = RX_FRAME_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic                           rx_tick,
  input  logic                           line_in,
  input  cfg_t                           cfg,
  output logic                           frame_end,
  output logic [3:0]                     bytes_next,
  output logic [RX_FRAME_BYTES-1:0][7:0] rx_store
);

  localparam int BW = $clog2(RX_FRAME_BYTES + 1);
  localparam int IW = $clog2(RX_FRAME_BYTES);

  logic          last_level, last_level_next;
  logic [7:0]    pulse_count, pulse_count_next;
  logic          synced, synced_next;
  logic          in_frame, in_frame_next;
  logic [2:0]    rx_bit_index, rx_bit_index_next;
  logic [BW-1:0] rx_byte_index, rx_byte_index_next;
  logic [BW-1:0] done_count, done_count_next;
  logic          store_wr;
  logic [7:0]    store_wdata;
  logic [IW-1:0] store_addr;
  logic [7:0]    done_wide;

  assign store_addr = rx_byte_index[IW-1:0];
  assign done_wide  = 8'(done_count_next);
  assign bytes_next = done_wide[3:0];

  always_comb begin
    last_level_next    = last_level;
    pulse_count_next   = pulse_count;
    synced_next        = synced;
    in_frame_next      = in_frame;
    rx_bit_index_next  = rx_bit_index;
    rx_byte_index_next = rx_byte_index;
    done_count_next    = done_count;
    frame_end          = 1'b0;
    store_wr           = 1'b0;
    store_wdata        = {line_in, rx_store[store_addr][7:1]};
    if (step && rx_tick) begin
      if (!line_in) begin
        if (last_level) begin
          // falling edge: pulse_count holds the high length
          last_level_next  = 1'b0;
          pulse_count_next = 8'd0;
          if (synced) begin
            if (pulse_count == cfg.bit_split) begin
              rx_bit_index_next  = 3'd0;
              rx_byte_index_next = '0;
              synced_next        = 1'b0;
            end else if (rx_byte_index < BW'(RX_FRAME_BYTES)) begin
              store_wr          = 1'b1;
              store_wdata       = {(pulse_count < cfg.bit_split), rx_store[store_addr][7:1]};
              rx_bit_index_next = rx_bit_index + 3'd1;
              if (rx_bit_index_next == 3'd0) begin
                rx_byte_index_next = rx_byte_index + BW'(1);
              end
            end
          end else if (pulse_count > cfg.sync_min && pulse_count < cfg.sync_max) begin
            synced_next   = 1'b1;
            in_frame_next = 1'b1;
          end
        end else begin
          if (pulse_count != COUNT_MAX) begin
            pulse_count_next = pulse_count + 8'd1;
          end
          if (pulse_count_next >= cfg.idle_end && in_frame) begin
            frame_end          = 1'b1;
            done_count_next    = rx_byte_index;
            rx_byte_index_next = '0;
            synced_next        = 1'b0;
            in_frame_next      = 1'b0;
          end
        end
      end else begin
        if (!last_level) begin
          last_level_next  = 1'b1;
          pulse_count_next = 8'd0;
        end else if (pulse_count != COUNT_MAX) begin
          pulse_count_next = pulse_count + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level    <= 1'b0;
      pulse_count   <= 8'd0;
      synced        <= 1'b0;
      in_frame      <= 1'b0;
      rx_bit_index  <= 3'd0;
      rx_byte_index <= '0;
      done_count    <= '0;
      rx_store      <= '0;
    end else begin
      last_level    <= last_level_next;
      pulse_count   <= pulse_count_next;
      synced        <= synced_next;
      in_frame      <= in_frame_next;
      rx_bit_index  <= rx_bit_index_next;
      rx_byte_index <= rx_byte_index_next;
      done_count    <= done_count_next;
      if (store_wr) begin
        rx_store[store_addr] <= store_wdata;
      end
    end
  end

endmodule

>>> sv/pwlr_tx.sv
// transmitter: reply build at frame end and pulse-width serializer
module pwlr_tx import pwlr_pkg::*; #(
  parameter int RX_FRAME_BYTES   = RX_FRAME_BYTES_DEF,
  parameter int REPLY_DATA_BYTES = REPLY_DATA_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic                           tx_tick,
  input  logic                           frame_end,
  input  logic [RX_FRAME_BYTES-1:0][7:0] rx_store,
  input  cfg_t                           cfg,
  output logic                           line_level_next,
  output logic                           tx_active_next
);

  localparam int TBW = $clog2(REPLY_DATA_BYTES + 3);
  localparam int RW  = (REPLY_DATA_BYTES > 1) ? $clog2(REPLY_DATA_BYTES) : 1;

  logic [REPLY_DATA_BYTES-1:0][7:0] reply_store, reply_built, reply_store_next;
  logic           tx_active, active_built;
  logic [7:0]     tx_tick_count, tx_tick_count_next;
  logic [7:0]     tx_low_start, tx_low_start_next;
  logic           tx_in_low, tx_in_low_next;
  logic [7:0]     tx_shift, shift_built, tx_shift_next;
  logic [3:0]     tx_bit_index, tx_bit_index_next;
  logic [TBW-1:0] tx_byte_index, byte_built, tx_byte_index_next;
  logic [7:0]     tx_checksum, checksum_built, tx_checksum_next;
  logic           line_level;
  logic [8:0]     sync_end;
  logic [8:0]     low_end;
  logic [TBW-1:0] reply_idx;

  assign sync_end  = {1'b0, cfg.tx_sync_ticks} + 9'd1;
  assign low_end   = {1'b0, tx_low_start} + 9'(cfg.tx_zero_low);
  assign reply_idx = tx_byte_index_next - TBW'(1);

  // frame end loads the reply before this item's tx tick is handled
  always_comb begin
    reply_built    = reply_store;
    shift_built    = tx_shift;
    active_built   = tx_active;
    checksum_built = tx_checksum;
    byte_built     = tx_byte_index;
    if (step && frame_end) begin
      if (rx_store[0] == REQ_HDR_MERGE) begin
        shift_built    = RPL_HDR_MERGE;
        reply_built[0] = reply_store[0] | rx_store[1];
      end else if (rx_store[0] == REQ_HDR_MASK) begin
        shift_built    = RPL_HDR_MASK;
        reply_built[0] = (reply_store[0] & KEEP_HI_MASK) | (rx_store[1] & TAKE_LO_MASK);
      end
      for (int k = 1; k < REPLY_DATA_BYTES; k++) begin
        if (k + 1 < RX_FRAME_BYTES) begin
          reply_built[k] = rx_store[k + 1];
        end
      end
      active_built   = 1'b1;
      checksum_built = shift_built;
      byte_built     = '0;
    end
  end

  always_comb begin
    reply_store_next   = reply_built;
    tx_active_next     = active_built;
    tx_tick_count_next = tx_tick_count;
    tx_low_start_next  = tx_low_start;
    tx_in_low_next     = tx_in_low;
    tx_shift_next      = shift_built;
    tx_bit_index_next  = tx_bit_index;
    tx_byte_index_next = byte_built;
    tx_checksum_next   = checksum_built;
    line_level_next    = line_level;
    if (step && tx_tick && active_built) begin
      tx_tick_count_next = tx_tick_count + 8'd1;
      if (tx_tick_count_next == 8'd1) begin
        line_level_next = 1'b0;
      end else if ({1'b0, tx_tick_count_next} == sync_end) begin
        line_level_next = 1'b1;
      end else if ({1'b0, tx_tick_count_next} > sync_end) begin
        if (tx_in_low) begin
          // a one ends its low after one tick, a zero after tx_zero_low ticks
          if (shift_built[0] || {1'b0, tx_tick_count_next} == low_end) begin
            line_level_next   = 1'b1;
            tx_in_low_next    = 1'b0;
            tx_shift_next     = {1'b0, shift_built[7:1]};
            tx_bit_index_next = tx_bit_index + 4'd1;
          end
          if (tx_bit_index_next == 4'd8) begin
            tx_bit_index_next  = 4'd0;
            tx_byte_index_next = byte_built + TBW'(1);
            if (tx_byte_index_next < TBW'(REPLY_DATA_BYTES + 1)) begin
              tx_tick_count_next = sync_end[7:0];
              tx_shift_next      = reply_built[reply_idx[RW-1:0]];
              tx_checksum_next   = checksum_built + tx_shift_next;
            end else if (tx_byte_index_next < TBW'(REPLY_DATA_BYTES + 2)) begin
              tx_tick_count_next = sync_end[7:0];
              tx_shift_next      = checksum_built;
            end else begin
              tx_tick_count_next  = 8'd0;
              tx_active_next      = 1'b0;
              tx_byte_index_next  = '0;
              reply_store_next[0] = reply_built[0] & CLR_FLAG_MASK;
            end
          end
        end else begin
          line_level_next   = 1'b0;
          tx_in_low_next    = 1'b1;
          tx_low_start_next = tx_tick_count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_store   <= '0;
      tx_active     <= 1'b0;
      tx_tick_count <= 8'd0;
      tx_low_start  <= 8'd0;
      tx_in_low     <= 1'b0;
      tx_shift      <= 8'd0;
      tx_bit_index  <= 4'd0;
      tx_byte_index <= '0;
      tx_checksum   <= 8'd0;
      line_level    <= 1'b0;
    end else begin
      reply_store   <= reply_store_next;
      tx_active     <= tx_active_next;
      tx_tick_count <= tx_tick_count_next;
      tx_low_start  <= tx_low_start_next;
      tx_in_low     <= tx_in_low_next;
      tx_shift      <= tx_shift_next;
      tx_bit_index  <= tx_bit_index_next;
      tx_byte_index <= tx_byte_index_next;
      tx_checksum   <= tx_checksum_next;
      line_level    <= line_level_next;
    end
  end

endmodule

>>> sv/pulse_width_link_responder.sv
// Single-wire pulse-width link responder. Each sample item carries the rx and tx tick strobes
// and the sampled incoming level; each produces exactly one result item with the outgoing
// level, a frame-done flag, the byte count of the last received frame and the tx busy flag.
// One item is taken every clock cycle while the output is not stalled: the item sits in an
// input register, the receiver and transmitter state update in combinational logic, and the
// result lands in an output register. The user must write the registers over the APB port
// at byte address 4*index only while no item is in flight; the block does not enforce this.
module pulse_width_link_responder import pwlr_pkg::*; #(
  parameter int RX_FRAME_BYTES   = RX_FRAME_BYTES_DEF,
  parameter int REPLY_DATA_BYTES = REPLY_DATA_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_ready,
  input  sample_t            sample,
  output logic               result_valid,
  input  logic               result_ready,
  output result_t            result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  sample_t    stage;
  logic       stage_valid;
  logic       advance;
  cfg_t       cfg;
  logic       frame_end;
  logic [3:0] bytes_next;
  logic       line_level_next;
  logic       tx_active_next;
  logic [RX_FRAME_BYTES-1:0][7:0] rx_store;

  assign advance      = stage_valid && (!result_valid || result_ready);
  assign sample_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (sample_valid && sample_ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      stage <= sample;
    end
  end

  pwlr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pwlr_rx #(
    .RX_FRAME_BYTES (RX_FRAME_BYTES)
  ) u_rx (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .rx_tick    (stage.rx_tick),
    .line_in    (stage.line_in),
    .cfg        (cfg),
    .frame_end  (frame_end),
    .bytes_next (bytes_next),
    .rx_store   (rx_store)
  );

  pwlr_tx #(
    .RX_FRAME_BYTES   (RX_FRAME_BYTES),
    .REPLY_DATA_BYTES (REPLY_DATA_BYTES)
  ) u_tx (
    .clk             (clk),
    .rst             (rst),
    .step            (advance),
    .tx_tick         (stage.tx_tick),
    .frame_end       (frame_end),
    .rx_store        (rx_store),
    .cfg             (cfg),
    .line_level_next (line_level_next),
    .tx_active_next  (tx_active_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.line_out       <= line_level_next;
      result.frame_done     <= frame_end;
      result.bytes_received <= bytes_next;
      result.tx_busy        <= tx_active_next;
    end
  end

endmodule
